// File: hw/rtl/rvcc_pkg.sv
`default_nettype none
package rvcc_pkg;

  localparam int unsigned ValveW  = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [ByteW-1:0] AUTH_KEY_RESET = 8'd3;

  // valve drive bit positions
  localparam int unsigned V_COMMON      = 0;
  localparam int unsigned V_LEFT        = 1;
  localparam int unsigned V_RIGHT       = 2;
  localparam int unsigned V_UNLOAD      = 3;
  localparam int unsigned V_UNLOAD_STOP = 4;
  localparam int unsigned V_BASKET_UP   = 5;
  localparam int unsigned V_BASKET_DN   = 6;
  localparam int unsigned V_STRIP_UP    = 7;
  localparam int unsigned V_STRIP_DN    = 8;
  localparam int unsigned V_PREP_DN     = 9;
  localparam int unsigned V_PREP_UP     = 10;
  localparam int unsigned V_RUN         = 11;
  localparam int unsigned V_REVERSE     = 12;
  localparam int unsigned V_COMMON2     = 13;
  localparam int unsigned V_LAMP        = 14;
  localparam int unsigned V_SPARE       = 15;

  // button codes
  localparam logic [ByteW-1:0] CMD_RELEASE      = 8'd0;
  localparam logic [ByteW-1:0] CMD_AUTO         = 8'd1;
  localparam logic [ByteW-1:0] CMD_STRIP        = 8'd2;
  localparam logic [ByteW-1:0] CMD_JOG_STRIP_UP = 8'd3;
  localparam logic [ByteW-1:0] CMD_JOG_STRIP_DN = 8'd4;
  localparam logic [ByteW-1:0] CMD_JOG_LEFT     = 8'd6;
  localparam logic [ByteW-1:0] CMD_JOG_PREP_UP  = 8'd9;
  localparam logic [ByteW-1:0] CMD_JOG_PREP_DN  = 8'd10;
  localparam logic [ByteW-1:0] CMD_JOG_BASK_UP  = 8'd11;
  localparam logic [ByteW-1:0] CMD_JOG_BASK_DN  = 8'd12;
  localparam logic [ByteW-1:0] CMD_UNLOAD_START = 8'd13;
  localparam logic [ByteW-1:0] CMD_UNLOAD_STOP  = 8'd14;
  localparam logic [ByteW-1:0] CMD_LAMP         = 8'd15;
  localparam logic [ByteW-1:0] CMD_REVERSE      = 8'd16;
  localparam logic [ByteW-1:0] CMD_JOG_RIGHT    = 8'd17;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] key_byte;
    logic [ByteW-1:0] command_byte;
    logic             tank_sensor;
    logic             down_sensor;
    logic             up_sensor;
    logic             right_sensor;
    logic             left_sensor;
  } rvcc_item_t;

  typedef struct packed {
    logic [ValveW-1:0] valve;
    logic              auto_mode;
    logic              strip_mode;
    logic              unload_mode;
    logic              lamp_mode;
    logic              press_latch;
    logic              auto_gate;
  } rvcc_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rvcc_step.sv
`default_nettype none
module rvcc_step
  import rvcc_pkg::*;
(
  input  wire rvcc_item_t       item,
  input  wire rvcc_state_t      state,
  input  wire [ByteW-1:0]       auth_key,
  output rvcc_state_t           state_nxt
);

  rvcc_state_t s;
  logic        any_req;

  always_comb begin
    s = state;
    any_req = item.down_sensor | item.up_sensor | item.right_sensor | item.left_sensor;

    if (item.kind && (item.key_byte == auth_key)) begin
      s.auto_gate = 1'b0;
      if (item.command_byte == CMD_RELEASE) begin
        // rebuild latched valves from the modes, re-arm
        s.valve            = '0;
        s.valve[V_LAMP]    = s.strip_mode;
        s.valve[V_RUN]     = s.strip_mode;
        s.valve[V_UNLOAD]  = s.unload_mode;
        s.valve[V_SPARE]   = s.lamp_mode;
        s.press_latch      = 1'b0;
        s.auto_gate        = 1'b1;
      end else if (!s.press_latch) begin
        case (item.command_byte)
          CMD_AUTO:         s.auto_mode  = !s.auto_mode;
          CMD_STRIP:        s.strip_mode = !s.strip_mode;
          CMD_UNLOAD_START: if (item.tank_sensor) s.unload_mode = 1'b1;
          CMD_UNLOAD_STOP:  s.unload_mode = 1'b0;
          CMD_LAMP:         s.lamp_mode  = !s.lamp_mode;
          CMD_JOG_STRIP_UP: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_STRIP_UP] = 1'b1;
          end
          CMD_JOG_STRIP_DN: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_STRIP_DN] = 1'b1;
          end
          CMD_JOG_RIGHT: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_RIGHT] = 1'b1;
          end
          CMD_JOG_LEFT: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_LEFT] = 1'b1;
          end
          CMD_JOG_PREP_UP: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_PREP_UP] = 1'b1;
          end
          CMD_JOG_PREP_DN: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_PREP_DN] = 1'b1;
          end
          CMD_JOG_BASK_UP: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_BASKET_UP] = 1'b1;
          end
          CMD_JOG_BASK_DN: begin
            s.valve[V_COMMON] = 1'b1; s.valve[V_BASKET_DN] = 1'b1;
          end
          CMD_REVERSE: begin
            if (s.valve[V_RUN]) begin
              s.valve[V_COMMON2] = 1'b1;
              s.valve[V_RUN]     = 1'b0;
              s.valve[V_REVERSE] = 1'b1;
            end
            if (s.valve[V_UNLOAD]) begin
              s.valve[V_REVERSE]     = 1'b0;
              s.valve[V_UNLOAD]      = 1'b0;
              s.unload_mode          = 1'b0;
              s.valve[V_UNLOAD_STOP] = 1'b1;
            end else begin
              s.valve[V_COMMON2] = 1'b1;
              s.valve[V_REVERSE] = 1'b1;
            end
          end
          default: ;
        endcase
        // unknown codes still latch the press
        s.press_latch = 1'b1;
      end
    end

    if (s.auto_mode && s.auto_gate) begin
      s.valve[V_STRIP_DN] = item.down_sensor;
      s.valve[V_STRIP_UP] = item.up_sensor;
      s.valve[V_RIGHT]    = item.right_sensor;
      s.valve[V_LEFT]     = item.left_sensor;
      s.valve[V_COMMON]   = any_req | s.valve[V_COMMON];
      if (!any_req) begin
        s.valve[V_COMMON] = 1'b0;
      end
    end

    state_nxt = s;
  end

endmodule
`default_nettype wire

// File: hw/rtl/remote_valve_command_controller_unit.sv
// Remote valve command controller. Each request on the in_ channel is one control
// pass (optional radio key/command plus five sensor bits) and yields exactly one
// result on the out_ channel: the sixteen valve drives and the four mode latches
// after that pass. A request is captured in an input register and evaluated into
// the result register, one request per clock while out_tready is high; mode and
// valve state between passes is updated with the result, which sets the rate. The
// key is written through the cfg_ channel (always ready, reset value 3); the user
// must do so only while no request is in flight; the block does not enforce it.
`default_nettype none
module remote_valve_command_controller_unit
  import rvcc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // [7:0] key_byte, [15:8] command_byte, [16] tank_sensor, [17] down_sensor,
  // [18] up_sensor, [19] right_sensor, [20] left_sensor, [23:21] zero
  input  wire [InDataW-1:0]   in_tdata,
  // [0] kind
  input  wire                 in_tuser,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // [15:0] valve_bits, [16] auto_on, [17] strip_on, [18] unload_on,
  // [19] lamp_on, [23:20] zero
  output logic [OutDataW-1:0] out_tdata,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [ByteW-1:0]     cfg_data
);

  logic        in_valid_r;
  rvcc_item_t  in_item_r;
  rvcc_state_t state_r;
  rvcc_state_t state_nxt;
  logic        out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] out_data_nxt;
  logic [ByteW-1:0]    auth_key_r;
  logic        adv;
  rvcc_item_t  in_item;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_item.kind         = in_tuser;
    in_item.key_byte     = in_tdata[7:0];
    in_item.command_byte = in_tdata[15:8];
    in_item.tank_sensor  = in_tdata[16];
    in_item.down_sensor  = in_tdata[17];
    in_item.up_sensor    = in_tdata[18];
    in_item.right_sensor = in_tdata[19];
    in_item.left_sensor  = in_tdata[20];
  end

  rvcc_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .auth_key  (auth_key_r),
    .state_nxt (state_nxt)
  );

  assign out_data_nxt = {4'b0000, state_nxt.lamp_mode, state_nxt.unload_mode,
                         state_nxt.strip_mode, state_nxt.auto_mode, state_nxt.valve};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      auth_key_r  <= AUTH_KEY_RESET;
      state_r     <= '{valve: '0, auto_mode: 1'b0, strip_mode: 1'b0,
                       unload_mode: 1'b0, lamp_mode: 1'b0, press_latch: 1'b0,
                       auto_gate: 1'b1};
    end else begin
      if (cfg_valid) begin
        auth_key_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: hw/rtl/rvcc_checker.sv
`default_nettype none
module rvcc_checker
  import rvcc_pkg::*;
(
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_tready,
  input wire                 out_tvalid,
  input wire                 out_tready,
  input wire [OutDataW-1:0]  out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input side backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output free");

  // a direction valve never drives without the common valve
  a_dir_common: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[V_LEFT] || out_tdata[V_RIGHT] ||
                   out_tdata[V_STRIP_UP] || out_tdata[V_STRIP_DN])
    |-> out_tdata[V_COMMON])
    else $error("direction valve without common");

  // unload and unload stop are exclusive
  a_unload_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[V_UNLOAD] && out_tdata[V_UNLOAD_STOP]))
    else $error("unload and unload stop both energized");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind remote_valve_command_controller_unit rvcc_checker u_rvcc_checker (.*);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rvcc_pkg::*;

  // button codes the block does not decode
  localparam logic [ByteW-1:0] CMD_UNKNOWN_LO = 8'd5;
  localparam logic [ByteW-1:0] CMD_UNKNOWN_HI = 8'hFF;
  localparam logic             KIND_PLAIN     = 1'b0;
  localparam logic             KIND_MESSAGE   = 1'b1;
  localparam int unsigned      RandomPasses   = 230;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [7:0] key, [15:8] command, [16] tank, [17] down,
                                   // [18] up, [19] right, [20] left, [23:21] zero
  logic                in_tuser;   // [0] kind
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [15:0] valves, [16] auto, [17] strip, [18] unload,
                                   // [19] lamp, [23:20] zero
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ByteW-1:0]    cfg_data;

  // controller state as the checker sees it
  logic [ValveW-1:0] mdl_valves;
  logic              mdl_auto;
  logic              mdl_strip;
  logic              mdl_unload;
  logic              mdl_lamp;
  logic              mdl_held;
  logic              mdl_steer_en;
  logic [ByteW-1:0]  mdl_key;

  logic [OutDataW-1:0] pending_outputs[$];

  int  fail_count;
  int  mismatch_count;
  int  passes_sent;
  int  results_checked;
  int  key_settings;
  bit  idle_on;
  int  stall_left;

  remote_valve_command_controller_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void energize(input int unsigned bit_pos);
    mdl_valves[V_COMMON] = 1'b1;
    mdl_valves[bit_pos]  = 1'b1;
  endfunction

  function automatic void steer(input int unsigned bit_pos, input logic req);
    if (req) energize(bit_pos);
    else mdl_valves[bit_pos] = 1'b0;
  endfunction

  // advance the controller state by one pass and return the drives and modes after it
  function automatic logic [OutDataW-1:0] valve_outputs_after(input rvcc_item_t it);
    if (it.kind && it.key_byte == mdl_key) begin
      mdl_steer_en = 1'b0;
      if (it.command_byte == CMD_RELEASE) begin
        mdl_valves           = '0;
        mdl_valves[V_LAMP]   = mdl_strip;
        mdl_valves[V_RUN]    = mdl_strip;
        mdl_valves[V_UNLOAD] = mdl_unload;
        mdl_valves[V_SPARE]  = mdl_lamp;
        mdl_held             = 1'b0;
        mdl_steer_en         = 1'b1;
      end else if (!mdl_held) begin
        case (it.command_byte)
          CMD_AUTO:         mdl_auto = !mdl_auto;
          CMD_STRIP:        mdl_strip = !mdl_strip;
          CMD_UNLOAD_START: if (it.tank_sensor) mdl_unload = 1'b1;
          CMD_UNLOAD_STOP:  mdl_unload = 1'b0;
          CMD_LAMP:         mdl_lamp = !mdl_lamp;
          CMD_JOG_STRIP_UP: energize(V_STRIP_UP);
          CMD_JOG_STRIP_DN: energize(V_STRIP_DN);
          CMD_JOG_RIGHT:    energize(V_RIGHT);
          CMD_JOG_LEFT:     energize(V_LEFT);
          CMD_JOG_PREP_UP:  energize(V_PREP_UP);
          CMD_JOG_PREP_DN:  energize(V_PREP_DN);
          CMD_JOG_BASK_UP:  energize(V_BASKET_UP);
          CMD_JOG_BASK_DN:  energize(V_BASKET_DN);
          CMD_REVERSE: begin
            if (mdl_valves[V_RUN]) begin
              mdl_valves[V_COMMON2] = 1'b1;
              mdl_valves[V_RUN]     = 1'b0;
              mdl_valves[V_REVERSE] = 1'b1;
            end
            if (mdl_valves[V_UNLOAD]) begin
              mdl_valves[V_REVERSE]     = 1'b0;
              mdl_valves[V_UNLOAD]      = 1'b0;
              mdl_unload                = 1'b0;
              mdl_valves[V_UNLOAD_STOP] = 1'b1;
            end else begin
              mdl_valves[V_COMMON2] = 1'b1;
              mdl_valves[V_REVERSE] = 1'b1;
            end
          end
          default: ;
        endcase
        mdl_held = 1'b1;
      end
    end
    if (mdl_auto && mdl_steer_en) begin
      steer(V_STRIP_DN, it.down_sensor);
      steer(V_STRIP_UP, it.up_sensor);
      steer(V_RIGHT, it.right_sensor);
      steer(V_LEFT, it.left_sensor);
      if (!(it.down_sensor || it.up_sensor || it.right_sensor || it.left_sensor))
        mdl_valves[V_COMMON] = 1'b0;
    end
    return {4'b0, mdl_lamp, mdl_unload, mdl_strip, mdl_auto, mdl_valves};
  endfunction

  // sensors packed as {left, right, up, down, tank}
  function automatic rvcc_item_t make_pass(input logic kind, input logic [ByteW-1:0] key,
                                           input logic [ByteW-1:0] cmd, input logic [4:0] sens);
    rvcc_item_t it;
    it.kind         = kind;
    it.key_byte     = key;
    it.command_byte = cmd;
    it.tank_sensor  = sens[0];
    it.down_sensor  = sens[1];
    it.up_sensor    = sens[2];
    it.right_sensor = sens[3];
    it.left_sensor  = sens[4];
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ByteW-1:0] pick_button();
    case ($urandom_range(0, 14))
      0:       return CMD_AUTO;
      1:       return CMD_STRIP;
      2:       return CMD_JOG_STRIP_UP;
      3:       return CMD_JOG_STRIP_DN;
      4:       return CMD_JOG_LEFT;
      5:       return CMD_JOG_PREP_UP;
      6:       return CMD_JOG_PREP_DN;
      7:       return CMD_JOG_BASK_UP;
      8:       return CMD_JOG_BASK_DN;
      9:       return CMD_UNLOAD_START;
      10:      return CMD_UNLOAD_STOP;
      11:      return CMD_LAMP;
      12:      return CMD_REVERSE;
      13:      return CMD_JOG_RIGHT;
      default: return CMD_UNKNOWN_LO;
    endcase
  endfunction

  // mostly press/release sequences under the right key, the rest noise
  function automatic rvcc_item_t random_pass();
    int         r;
    logic [4:0] sens;
    r    = $urandom_range(0, 99);
    sens = 5'($urandom_range(0, 31));
    if (r < 10)
      return make_pass(KIND_PLAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sens);
    if (r < 18)
      return make_pass(KIND_MESSAGE, mdl_key ^ 8'($urandom_range(1, 255)),
                       8'($urandom_range(0, 255)), sens);
    if (r < 23)
      return make_pass(KIND_MESSAGE, mdl_key, 8'($urandom_range(0, 255)), sens);
    if (mdl_held ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 6) == 0))
      return make_pass(KIND_MESSAGE, mdl_key, CMD_RELEASE, sens);
    return make_pass(KIND_MESSAGE, mdl_key, pick_button(), sens);
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_pass(input rvcc_item_t it);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {3'b0, it.left_sensor, it.right_sensor, it.up_sensor, it.down_sensor,
                  it.tank_sensor, it.command_byte, it.key_byte};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pending_outputs.push_back(valve_outputs_after(it));
    passes_sent++;
  endtask

  task automatic press(input logic [ByteW-1:0] cmd, input logic [4:0] sens);
    send_pass(make_pass(KIND_MESSAGE, mdl_key, cmd, sens));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_key(input logic [ByteW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    mdl_key = value;
    key_settings++;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $time, exp_v, act_v);
  endtask

  // compare each accepted result with the oldest prediction
  always @(negedge clk) begin
    logic [OutDataW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        note_mismatch("unexpected result", 16'h0, out_tdata[15:0]);
      end else begin
        want = pending_outputs.pop_front();
        results_checked++;
        if (out_tdata[15:0] !== want[15:0]) note_mismatch("valve_bits", want[15:0], out_tdata[15:0]);
        if (out_tdata[16] !== want[16])
          note_mismatch("auto_on", 16'(want[16]), 16'(out_tdata[16]));
        if (out_tdata[17] !== want[17])
          note_mismatch("strip_on", 16'(want[17]), 16'(out_tdata[17]));
        if (out_tdata[18] !== want[18])
          note_mismatch("unload_on", 16'(want[18]), 16'(out_tdata[18]));
        if (out_tdata[19] !== want[19])
          note_mismatch("lamp_on", 16'(want[19]), 16'(out_tdata[19]));
      end
    end
  end

  // result side back-pressure
  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // mode toggles, press latch, steering suspend and the valve rebuild on release
  task automatic test_modes_and_latch();
    send_pass(make_pass(KIND_PLAIN, mdl_key, CMD_AUTO, 5'b11111));
    press(CMD_AUTO, 5'b00010);
    send_pass(make_pass(KIND_PLAIN, 8'h00, 8'h00, 5'b01010));
    press(CMD_RELEASE, 5'b00100);
    send_pass(make_pass(KIND_PLAIN, 8'hFF, 8'hFF, 5'b00000));
    press(CMD_AUTO, 5'b11111);
    press(CMD_STRIP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_STRIP, 5'b00000);
    press(CMD_RELEASE, 5'b11110);
    press(CMD_UNLOAD_START, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_UNLOAD_START, 5'b00001);
    press(CMD_RELEASE, 5'b00001);
    press(CMD_REVERSE, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_LAMP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_UNLOAD_START, 5'b00001);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_UNLOAD_STOP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_UNKNOWN_LO, 5'b00000);
    press(CMD_AUTO, 5'b00000);
    send_pass(make_pass(KIND_MESSAGE, mdl_key ^ 8'h01, CMD_RELEASE, 5'b00000));
    press(CMD_RELEASE, 5'b00000);
    wait_idle();
  endtask

  // jog valves under key 00 and reverse under key FF, the two extreme keys
  task automatic test_jogs_at_key_extremes();
    write_key(8'h00);
    press(CMD_JOG_STRIP_UP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_STRIP_DN, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_LEFT, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_RIGHT, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_PREP_UP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_PREP_DN, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_BASK_UP, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    press(CMD_JOG_BASK_DN, 5'b00000);
    send_pass(make_pass(KIND_MESSAGE, AUTH_KEY_RESET, CMD_RELEASE, 5'b00000));
    press(CMD_RELEASE, 5'b00000);
    wait_idle();
    write_key(8'hFF);
    press(CMD_REVERSE, 5'b00000);
    press(CMD_RELEASE, 5'b00000);
    send_pass(make_pass(KIND_MESSAGE, 8'h00, CMD_AUTO, 5'b00000));
    press(CMD_UNKNOWN_HI, 5'b11111);
    press(CMD_RELEASE, 5'b00000);
    wait_idle();
  endtask

  // random sequences across several key settings, the first one without idling
  task automatic test_random_passes();
    logic [ByteW-1:0] keys[5];
    keys[0] = 8'($urandom_range(0, 255));
    keys[1] = 8'hFF;
    keys[2] = 8'h00;
    keys[3] = 8'($urandom_range(0, 255));
    keys[4] = AUTH_KEY_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      idle_on = (ph != 0);
      write_key(keys[ph]);
      repeat (RandomPasses) send_pass(random_pass());
      wait_idle();
    end
  endtask

  initial begin
    fail_count      = 0;
    mismatch_count  = 0;
    passes_sent     = 0;
    results_checked = 0;
    key_settings    = 0;
    idle_on         = 1'b1;
    mdl_valves      = '0;
    mdl_auto        = 1'b0;
    mdl_strip       = 1'b0;
    mdl_unload      = 1'b0;
    mdl_lamp        = 1'b0;
    mdl_held        = 1'b0;
    mdl_steer_en    = 1'b1;
    mdl_key         = AUTH_KEY_RESET;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_modes_and_latch();
    test_jogs_at_key_extremes();
    test_random_passes();

    repeat (10) @(posedge clk);
    $display("%0d control passes sent and %0d results checked over %0d key settings,",
             passes_sent, results_checked, key_settings);
    $display("covering mode toggles, jogs, reverse, held and unknown buttons and wrong keys");
    if (fail_count == 0) begin
      $display("[remote_valve_command_controller_unit] OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("[remote_valve_command_controller_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_outputs.size());
    $display("[remote_valve_command_controller_unit] ERROR");
    $finish;
  end

endmodule
